/* rtl/barometer_pressure_compensation_assert.svh */
// Assertion macros shared by the barometer pressure compensation RTL.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bpc_pkg.sv */
// Package for the barometer pressure compensation block.
// Holds types, register indexes, constants and arithmetic helpers; no dependencies.
package bpc_pkg;

    localparam int DIV_W     = 32;
    localparam int DIV_PAY_W = 53;
    localparam int Q_DEPTH   = 2;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_P_SQ     = 32'd3038;
    localparam logic [31:0] C_P_LIN    = 32'hFFFF_E343;
    localparam logic [31:0] C_P_OFS    = 32'd3791;

    typedef enum logic [2:0] {
        REG_AC1_AC2  = 3'd0,
        REG_AC3_AC4  = 3'd1,
        REG_AC5_AC6  = 3'd2,
        REG_B1_B2    = 3'd3,
        REG_MC_MD    = 3'd4,
        REG_OVERSAMP = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_coeff;

    typedef struct packed {
        logic [15:0] ut;
        logic [18:0] up;
    } t_item;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] sh);
        return $unsigned($signed(v) >>> sh);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

endpackage

/* rtl/bpc_front.sv */
// Front end: configuration registers and the short word queue feeding the back end.
// Depends on bpc_pkg.
module bpc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_data,
    input  logic            push,
    output logic            full,
    input  logic [15:0]     i_raw_temperature,
    input  logic [18:0]     i_raw_pressure,
    input  logic            i_take,
    output logic            o_valid,
    output bpc_pkg::t_item  o_item,
    output bpc_pkg::t_coeff o_coeff
);

    logic [31:0] r_ac1_ac2;
    logic [31:0] r_ac3_ac4;
    logic [31:0] r_ac5_ac6;
    logic [31:0] r_b1_b2;
    logic [31:0] r_mc_md;
    logic [1:0]  r_oss;

    bpc_pkg::t_item r_q [bpc_pkg::Q_DEPTH];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           w_wr;
    logic           w_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1_ac2 <= '0;
            r_ac3_ac4 <= '0;
            r_ac5_ac6 <= '0;
            r_b1_b2   <= '0;
            r_mc_md   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_we) begin
            unique case (bpc_pkg::t_reg_idx'(i_cfg_index))
                bpc_pkg::REG_AC1_AC2:  r_ac1_ac2 <= i_cfg_data;
                bpc_pkg::REG_AC3_AC4:  r_ac3_ac4 <= i_cfg_data;
                bpc_pkg::REG_AC5_AC6:  r_ac5_ac6 <= i_cfg_data;
                bpc_pkg::REG_B1_B2:    r_b1_b2   <= i_cfg_data;
                bpc_pkg::REG_MC_MD:    r_mc_md   <= i_cfg_data;
                bpc_pkg::REG_OVERSAMP: r_oss     <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_coeff = '{ac1: r_ac1_ac2[31:16], ac2: r_ac1_ac2[15:0],
                       ac3: r_ac3_ac4[31:16], ac4: r_ac3_ac4[15:0],
                       ac5: r_ac5_ac6[31:16], ac6: r_ac5_ac6[15:0],
                       b1: r_b1_b2[31:16], b2: r_b1_b2[15:0],
                       mc: r_mc_md[31:16], md: r_mc_md[15:0], oss: r_oss};

    assign full    = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_q[r_rd_ptr];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= '{ut: i_raw_temperature, up: i_raw_pressure};
        end
    end

endmodule

/* rtl/bpc_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, with side payload.
// Depends on bpc_pkg.
module bpc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bpc_pkg::DIV_W-1:0]     i_num,
    input  logic [bpc_pkg::DIV_W-1:0]     i_den,
    input  logic [bpc_pkg::DIV_PAY_W-1:0] i_pay,
    output logic                          o_valid,
    output logic [bpc_pkg::DIV_W-1:0]     o_quo,
    output logic [bpc_pkg::DIV_PAY_W-1:0] o_pay
);

    localparam int W = bpc_pkg::DIV_W;

    logic [W-1:0]                  r_rem [W];
    logic [W-1:0]                  r_num [W];
    logic [W-1:0]                  r_den [W];
    logic [bpc_pkg::DIV_PAY_W-1:0] r_pay [W];
    logic [W-1:0]                  r_v;
    logic [W-1:0]                  n_rem [W];
    logic [W-1:0]                  n_num [W];

    always_comb begin
        logic [W:0]   t;
        logic [W:0]   d;
        logic [W-1:0] prem;
        logic [W-1:0] pnum;
        logic [W-1:0] pden;
        for (int k = 0; k < W; k++) begin
            prem     = (k == 0) ? '0 : r_rem[(k == 0) ? 0 : k - 1];
            pnum     = (k == 0) ? i_num : r_num[(k == 0) ? 0 : k - 1];
            pden     = (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
            t        = {prem, pnum[W-1]};
            d        = t - {1'b0, pden};
            n_rem[k] = d[W] ? t[W-1:0] : d[W-1:0];
            n_num[k] = {pnum[W-2:0], !d[W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[W-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_den[k] <= (k == 0) ? i_den : r_den[(k == 0) ? 0 : k - 1];
                r_pay[k] <= (k == 0) ? i_pay : r_pay[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quo   = r_num[W-1];
    assign o_pay   = r_pay[W-1];

endmodule

/* rtl/bpc_back.sv */
// Back end: stalling compensation pipeline with two dividers and the result register.
// Depends on bpc_pkg, bpc_div and the assertion macro header.
`include "barometer_pressure_compensation_assert.svh"
module bpc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpc_pkg::t_coeff i_coeff,
    input  logic            i_valid,
    input  bpc_pkg::t_item  i_item,
    output logic            o_take,
    input  logic            i_pop,
    output logic            o_valid,
    output logic [31:0]     o_temp,
    output logic [31:0]     o_pres,
    output logic            o_fault
);

    logic        adv;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

    logic        r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8, r_v9, r_v10, r_v11, r_v12;
    logic        r_v14, r_v15, r_v16, r_out_valid;
    logic [18:0] r1_up, r2_up, r3_up, r4_up, r5_up, r6_up, r7_up, r8_up, r9_up, r10_up;
    logic [31:0] r1_a, r2_m, r3_x1, r3_den, r3_num;
    logic [31:0] r4_b5, r5_temp, r5_b6;
    logic        r4_fault, r5_fault, r6_fault, r7_fault, r8_fault, r9_fault, r10_fault;
    logic        r11_fault, r12_fault, r14_fault, r15_fault, r16_fault, r_out_fault;
    logic [31:0] r6_temp, r7_temp, r8_temp, r9_temp, r10_temp, r11_temp, r12_temp;
    logic [31:0] r14_temp, r15_temp, r16_temp, r_out_temp, r_out_pres;
    logic [31:0] r6_msq, r6_mac2, r6_mac3;
    logic [31:0] r7_sq, r7_x2a, r7_x1c, r8_mb2, r8_mb1, r8_x2a, r8_x1c;
    logic [31:0] r9_x3a, r9_x3c, r10_b3, r10_u4, r11_b4m, r11_d7, r12_b4, r12_b7;
    logic [31:0] r14_p, r15_p, r15_m1, r15_m2, r16_p, r16_m3, r16_x2;

    logic [31:0] w_x1, w_b4, w_q1x2, w_s, w_x1p;
    logic [31:0] d1_num, d1_den, d2_num;
    logic        d1_valid, d2_valid, d2_hi;
    logic [31:0] d1_quo, d2_quo;
    logic [bpc_pkg::DIV_PAY_W-1:0] d1_pay_in, d1_pay, d2_pay_in, d2_pay;

    assign adv    = !r_out_valid || i_pop;
    assign o_take = adv;

    assign ac1 = bpc_pkg::sx16(i_coeff.ac1);
    assign ac2 = bpc_pkg::sx16(i_coeff.ac2);
    assign ac3 = bpc_pkg::sx16(i_coeff.ac3);
    assign ac4 = {16'd0, i_coeff.ac4};
    assign ac5 = {16'd0, i_coeff.ac5};
    assign ac6 = {16'd0, i_coeff.ac6};
    assign b1  = bpc_pkg::sx16(i_coeff.b1);
    assign b2  = bpc_pkg::sx16(i_coeff.b2);
    assign mc  = bpc_pkg::sx16(i_coeff.mc);
    assign md  = bpc_pkg::sx16(i_coeff.md);

    assign w_x1      = bpc_pkg::asr32(r2_m, 5'd15);
    assign d1_num    = r3_num[31] ? (32'd0 - r3_num) : r3_num;
    assign d1_den    = r3_den[31] ? (32'd0 - r3_den) : r3_den;
    assign d1_pay_in = {r3_up, r3_x1, r3_num[31] ^ r3_den[31], r3_den == 32'd0};

    bpc_div u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v3),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_pay   (d1_pay_in),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_pay   (d1_pay)
    );

    assign w_q1x2 = d1_pay[0] ? 32'd0 : (d1_pay[1] ? (32'd0 - d1_quo) : d1_quo);
    assign w_b4   = r11_b4m >> 15;

    assign d2_hi     = r12_b7[31];
    assign d2_num    = d2_hi ? r12_b7 : {r12_b7[30:0], 1'b0};
    assign d2_pay_in = {19'd0, r12_temp, r12_fault, d2_hi};

    bpc_div u_div_pres (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_v12),
        .i_num   (d2_num),
        .i_den   (r12_b4),
        .i_pay   (d2_pay_in),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_pay   (d2_pay)
    );

    assign w_s   = bpc_pkg::asr32(r14_p, 5'd8);
    assign w_x1p = bpc_pkg::asr32(r16_m3, 5'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
            r_v9 <= 1'b0; r_v10 <= 1'b0; r_v11 <= 1'b0; r_v12 <= 1'b0;
            r_v14 <= 1'b0; r_v15 <= 1'b0; r_v16 <= 1'b0; r_out_valid <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= d1_valid;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6; r_v8 <= r_v7;
            r_v9 <= r_v8; r_v10 <= r_v9; r_v11 <= r_v10; r_v12 <= r_v11;
            r_v14 <= d2_valid; r_v15 <= r_v14; r_v16 <= r_v15; r_out_valid <= r_v16;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_a  <= {16'd0, i_item.ut} - ac6;
            r1_up <= i_item.up;

            r2_m  <= r1_a * ac5;
            r2_up <= r1_up;

            r3_x1  <= w_x1;
            r3_den <= w_x1 + md;
            r3_num <= {mc[20:0], 11'd0};
            r3_up  <= r2_up;

            r4_b5    <= d1_pay[33:2] + w_q1x2;
            r4_fault <= d1_pay[0];
            r4_up    <= d1_pay[52:34];

            r5_temp  <= bpc_pkg::asr32(r4_b5 + 32'd8, 5'd4);
            r5_b6    <= r4_b5 - bpc_pkg::C_B6_OFS;
            r5_fault <= r4_fault;
            r5_up    <= r4_up;

            r6_msq   <= r5_b6 * r5_b6;
            r6_mac2  <= ac2 * r5_b6;
            r6_mac3  <= ac3 * r5_b6;
            r6_temp  <= r5_temp;
            r6_fault <= r5_fault;
            r6_up    <= r5_up;

            r7_sq    <= bpc_pkg::asr32(r6_msq, 5'd12);
            r7_x2a   <= bpc_pkg::asr32(r6_mac2, 5'd11);
            r7_x1c   <= bpc_pkg::asr32(r6_mac3, 5'd13);
            r7_temp  <= r6_temp;
            r7_fault <= r6_fault;
            r7_up    <= r6_up;

            r8_mb2   <= b2 * r7_sq;
            r8_mb1   <= b1 * r7_sq;
            r8_x2a   <= r7_x2a;
            r8_x1c   <= r7_x1c;
            r8_temp  <= r7_temp;
            r8_fault <= r7_fault;
            r8_up    <= r7_up;

            r9_x3a   <= bpc_pkg::asr32(r8_mb2, 5'd11) + r8_x2a;
            r9_x3c   <= bpc_pkg::asr32(r8_x1c + bpc_pkg::asr32(r8_mb1, 5'd16) + 32'd2, 5'd2);
            r9_temp  <= r8_temp;
            r9_fault <= r8_fault;
            r9_up    <= r8_up;

            r10_b3    <= bpc_pkg::asr32((({ac1[29:0], 2'd0} + r9_x3a) << i_coeff.oss) + 32'd2,
                                        5'd2);
            r10_u4    <= r9_x3c + bpc_pkg::C_B4_OFS;
            r10_temp  <= r9_temp;
            r10_fault <= r9_fault;
            r10_up    <= r9_up;

            r11_b4m   <= ac4 * r10_u4;
            r11_d7    <= {13'd0, r10_up} - r10_b3;
            r11_temp  <= r10_temp;
            r11_fault <= r10_fault;

            r12_b4    <= w_b4;
            r12_b7    <= r11_d7 * (bpc_pkg::C_B7_SCALE >> i_coeff.oss);
            r12_temp  <= r11_temp;
            r12_fault <= r11_fault || (w_b4 == 32'd0);

            r14_p     <= d2_pay[0] ? {d2_quo[30:0], 1'b0} : d2_quo;
            r14_temp  <= d2_pay[33:2];
            r14_fault <= d2_pay[1];

            r15_p     <= r14_p;
            r15_m1    <= w_s * w_s;
            r15_m2    <= bpc_pkg::C_P_LIN * r14_p;
            r15_temp  <= r14_temp;
            r15_fault <= r14_fault;

            r16_p     <= r15_p;
            r16_m3    <= r15_m1 * bpc_pkg::C_P_SQ;
            r16_x2    <= bpc_pkg::asr32(r15_m2, 5'd16);
            r16_temp  <= r15_temp;
            r16_fault <= r15_fault;

            r_out_temp  <= r16_temp;
            r_out_fault <= r16_fault;
            r_out_pres  <= r16_fault ? 32'd0 :
                           r16_p + bpc_pkg::asr32(w_x1p + r16_x2 + bpc_pkg::C_P_OFS, 5'd4);
        end
    end

    assign o_valid = r_out_valid;
    assign o_temp  = r_out_temp;
    assign o_pres  = r_out_pres;
    assign o_fault = r_out_fault;

    `BPC_ASSERT_NOW(a_fault_zero_pres, r_out_valid && r_out_fault, r_out_pres == 32'd0, "fault")
    `BPC_ASSERT_NEXT(a_stall_freeze, !adv, $stable(r_v4) && $stable(r_v14) && r_out_valid, "stall")
    `BPC_ASSERT_NEXT(a_stall_first, !adv && r_v1, r_v1 && $stable(r1_a), "first stage lost")

endmodule

/* rtl/barometer_pressure_compensation.sv */
// Barometric temperature and pressure compensation, 32-bit integer scheme.
// Throughput: one word per cycle; the fully pipelined datapath and its two 32-stage
// dividers take a new word every cycle while the result side keeps popping.
// Reset (i_rst_n low, synchronous) clears the coefficients, the queue and all valid bits.
// Depends on bpc_pkg, bpc_front and bpc_back.
module barometer_pressure_compensation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_raw_temperature,
    input  logic [18:0] i_raw_pressure,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_temperature_decidegrees,
    output logic [31:0] o_pressure_pascal,
    output logic        o_divide_fault
);

    bpc_pkg::t_coeff w_coeff;
    bpc_pkg::t_item  w_item;
    logic            w_valid;
    logic            w_take;
    logic            w_out_valid;

    bpc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_raw_temperature (i_raw_temperature),
        .i_raw_pressure    (i_raw_pressure),
        .i_take            (w_take),
        .o_valid           (w_valid),
        .o_item            (w_item),
        .o_coeff           (w_coeff)
    );

    bpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coeff (w_coeff),
        .i_valid (w_valid),
        .i_item  (w_item),
        .o_take  (w_take),
        .i_pop   (pop),
        .o_valid (w_out_valid),
        .o_temp  (o_temperature_decidegrees),
        .o_pres  (o_pressure_pascal),
        .o_fault (o_divide_fault)
    );

    assign empty = !w_out_valid;

endmodule
